FILE: rtl/char_grid_edit_engine_assert.svh
// assertion macros for the character grid edit engine checker
`ifndef CHAR_GRID_EDIT_ENGINE_ASSERT_SVH
`define CHAR_GRID_EDIT_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CGE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid edit check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CGE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid edit check failed");

`endif

FILE: rtl/cge_pkg.sv
// shared constants and types for the character grid edit engine
`timescale 1ns / 1ps
package cge_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 32;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int CHAR_W = 8;

  localparam logic [WID_W-1:0]  RESET_WIDTH  = WID_W'(16);
  localparam logic [HGT_W-1:0]  RESET_HEIGHT = HGT_W'(8);
  localparam logic [CHAR_W-1:0] RESET_CHAR   = 8'h60;

  typedef enum logic [1:0] {
    CMD_PAINT  = 2'd0,
    CMD_SWAP   = 2'd1,
    CMD_RESIZE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_OOB    = 2'd1,
    ST_REJECT = 2'd2
  } status_t;

endpackage

FILE: rtl/cge_ram.sv
// simple dual-port cell memory, one write port and one registered read port
`timescale 1ns / 1ps
module cge_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/char_grid_edit_engine.sv
// character grid edit engine: command sequencer around the cell memory
//
// usage
//   input channel in_*: one command word per handshake (paint, swap, resize, read),
//   accepted at a clock edge with in_valid high and in_stall low.
//   result channel out_*: exactly one result word per command, in command order,
//   taken at a clock edge with out_valid high and out_stall low.
//   cells sit in a 2048 x 8 memory with a row stride of 64, one write port and one registered read port.
// command work and throughput
//   a visible paint writes its cell as it is accepted and a visible read fetches its cell in S_READ;
//   each command, swaps on an empty grid and rejected or empty resizes too, registers its result in S_DONE.
//   swap and resize walk the grid one cell per cycle on the memory ports; one
//   command is in work at a time, in_stall is high until its result is registered.
// reset
//   rst_n low (synchronous) clears control; afterwards a clearing pass
//   fills the 16 x 8 starting grid with backticks while in_stall is high.
// stall
//   a result waits in the output register while out_stall is high; the next
//   command is still accepted and finishes its work, then waits for the register.
`timescale 1ns / 1ps
module char_grid_edit_engine
  import cge_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_command,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [CHAR_W-1:0] in_char_a,
  input  logic [CHAR_W-1:0] in_char_b,
  input  logic [WID_W-1:0]  in_req_width,
  input  logic [HGT_W-1:0]  in_req_height,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_cell_char,
  output logic [1:0]        out_status,
  output logic [WID_W-1:0]  out_width_now,
  output logic [HGT_W-1:0]  out_height_now
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_SWAP,
    S_FILL,
    S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [ROW_W-1:0]    scan_row_r, scan_row_nxt;
  logic [COL_W-1:0]    scan_col_r, scan_col_nxt;
  logic [WID_W-1:0]    scan_w_r, scan_w_nxt;
  logic [HGT_W-1:0]    scan_h_r, scan_h_nxt;
  logic                issue_r, issue_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   wa_r, wa_nxt;
  logic [CHAR_W-1:0]   char_a_r, char_a_nxt;
  logic [CHAR_W-1:0]   char_b_r, char_b_nxt;
  logic [WID_W-1:0]    cur_w_r, cur_w_nxt;
  logic [HGT_W-1:0]    cur_h_r, cur_h_nxt;
  logic [CHAR_W-1:0]   res_char_r, res_char_nxt;
  status_t             res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  logic [WID_W-1:0]    out_w_r, out_w_nxt;
  logic [HGT_W-1:0]    out_h_r, out_h_nxt;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [CHAR_W-1:0]   mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;
  logic [CHAR_W-1:0]   mem_rdata;

  logic [ADDR_W-1:0]   scan_addr;
  logic                last_col;
  logic                last_row;
  logic                scan_last;
  logic [ROW_W-1:0]    adv_row;
  logic [COL_W-1:0]    adv_col;
  logic                in_vis;
  logic                fill_hit;

  cge_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign scan_addr = {scan_row_r, scan_col_r};
  assign last_col  = (WID_W'(scan_col_r) + WID_W'(1)) == scan_w_r;
  assign last_row  = (HGT_W'(scan_row_r) + HGT_W'(1)) == scan_h_r;
  assign scan_last = last_col && last_row;
  assign adv_col   = last_col ? '0 : scan_col_r + COL_W'(1);
  assign adv_row   = last_col ? scan_row_r + ROW_W'(1) : scan_row_r;
  assign in_vis    = (WID_W'(in_col) < cur_w_r) && (HGT_W'(in_row) < cur_h_r);
  assign fill_hit  = (HGT_W'(scan_row_r) >= cur_h_r) || (WID_W'(scan_col_r) >= cur_w_r);

  always_comb begin
    state_nxt      = state_r;
    scan_row_nxt   = scan_row_r;
    scan_col_nxt   = scan_col_r;
    scan_w_nxt     = scan_w_r;
    scan_h_nxt     = scan_h_r;
    issue_nxt      = issue_r;
    pend_nxt       = pend_r;
    wa_nxt         = wa_r;
    char_a_nxt     = char_a_r;
    char_b_nxt     = char_b_r;
    cur_w_nxt      = cur_w_r;
    cur_h_nxt      = cur_h_r;
    res_char_nxt   = res_char_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_char_nxt   = out_char_r;
    out_status_nxt = out_status_r;
    out_w_nxt      = out_w_r;
    out_h_nxt      = out_h_r;
    mem_we         = 1'b0;
    mem_waddr      = scan_addr;
    mem_wdata      = char_a_r;
    mem_raddr      = scan_addr;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_wdata    = RESET_CHAR;
        scan_row_nxt = adv_row;
        scan_col_nxt = adv_col;
        if (scan_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          char_a_nxt     = in_char_a;
          char_b_nxt     = in_char_b;
          res_char_nxt   = '0;
          res_status_nxt = ST_DONE;
          scan_row_nxt   = '0;
          scan_col_nxt   = '0;
          state_nxt      = S_DONE;
          unique case (cmd_t'(in_command))
            CMD_PAINT: begin
              if (in_vis) begin
                mem_we    = 1'b1;
                mem_waddr = {in_row, in_col};
                mem_wdata = in_char_a;
              end else begin
                res_status_nxt = ST_OOB;
              end
            end
            CMD_READ: begin
              mem_raddr = {in_row, in_col};
              if (in_vis) begin
                state_nxt = S_READ;
              end else begin
                res_status_nxt = ST_OOB;
              end
            end
            CMD_SWAP: begin
              if ((cur_w_r != '0) && (cur_h_r != '0)) begin
                scan_w_nxt = cur_w_r;
                scan_h_nxt = cur_h_r;
                issue_nxt  = 1'b1;
                pend_nxt   = 1'b0;
                state_nxt  = S_SWAP;
              end
            end
            CMD_RESIZE: begin
              if ((in_req_width > WID_W'(MAX_WIDTH)) ||
                  (in_req_height > HGT_W'(MAX_HEIGHT))) begin
                res_status_nxt = ST_REJECT;
              end else if ((in_req_width == '0) || (in_req_height == '0)) begin
                cur_w_nxt = in_req_width;
                cur_h_nxt = in_req_height;
              end else begin
                scan_w_nxt = in_req_width;
                scan_h_nxt = in_req_height;
                state_nxt  = S_FILL;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        res_char_nxt = mem_rdata;
        state_nxt    = S_DONE;
      end
      S_SWAP: begin
        if (pend_r && (mem_rdata == char_a_r)) begin
          mem_we    = 1'b1;
          mem_waddr = wa_r;
          mem_wdata = char_b_r;
        end
        pend_nxt = issue_r;
        if (issue_r) begin
          wa_nxt       = scan_addr;
          scan_row_nxt = adv_row;
          scan_col_nxt = adv_col;
          if (scan_last) begin
            issue_nxt = 1'b0;
          end
        end
        if (!issue_r && !pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_FILL: begin
        mem_we       = fill_hit;
        scan_row_nxt = adv_row;
        scan_col_nxt = adv_col;
        if (scan_last) begin
          cur_w_nxt = scan_w_r;
          cur_h_nxt = scan_h_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_char_nxt   = res_char_r;
          out_status_nxt = res_status_r;
          out_w_nxt      = cur_w_r;
          out_h_nxt      = cur_h_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      scan_row_r  <= '0;
      scan_col_r  <= '0;
      scan_w_r    <= RESET_WIDTH;
      scan_h_r    <= RESET_HEIGHT;
      issue_r     <= 1'b0;
      pend_r      <= 1'b0;
      cur_w_r     <= RESET_WIDTH;
      cur_h_r     <= RESET_HEIGHT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_row_r  <= scan_row_nxt;
      scan_col_r  <= scan_col_nxt;
      scan_w_r    <= scan_w_nxt;
      scan_h_r    <= scan_h_nxt;
      issue_r     <= issue_nxt;
      pend_r      <= pend_nxt;
      cur_w_r     <= cur_w_nxt;
      cur_h_r     <= cur_h_nxt;
      out_valid_r <= out_valid_nxt;
    end
    wa_r         <= wa_nxt;
    char_a_r     <= char_a_nxt;
    char_b_r     <= char_b_nxt;
    res_char_r   <= res_char_nxt;
    res_status_r <= res_status_nxt;
    out_char_r   <= out_char_nxt;
    out_status_r <= out_status_nxt;
    out_w_r      <= out_w_nxt;
    out_h_r      <= out_h_nxt;
  end

  assign in_stall       = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_cell_char  = out_char_r;
  assign out_status     = out_status_r;
  assign out_width_now  = out_w_r;
  assign out_height_now = out_h_r;

endmodule

FILE: rtl/cge_checker.sv
// port-level checker for the character grid edit engine, bound to the top level
`timescale 1ns / 1ps
`include "char_grid_edit_engine_assert.svh"
module cge_checker
  import cge_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_cell_char,
  input logic [1:0]        out_status,
  input logic [WID_W-1:0]  out_width_now,
  input logic [HGT_W-1:0]  out_height_now
);

  // a result word is not dropped while the receiver stalls
  `CGE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

  // only one command in work: an accepted word makes the block busy
  `CGE_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // status is one of the three defined codes
  `CGE_ASSERT_IMP(a_status_code, out_valid, (out_status == ST_DONE) || (out_status == ST_OOB) || (out_status == ST_REJECT))

  // a failed command carries no character
  `CGE_ASSERT_IMP(a_fail_no_char, out_valid && (out_status != ST_DONE), out_cell_char == '0)

  // reported size never exceeds the store
  `CGE_ASSERT_IMP(a_size_limit, out_valid,
    (out_width_now <= WID_W'(MAX_WIDTH)) && (out_height_now <= HGT_W'(MAX_HEIGHT)))

endmodule

bind char_grid_edit_engine cge_checker u_cge_checker (.*);
